/* design/srr_pkg.sv */
// shared types and codes for the service registry
package srr_pkg;

  localparam logic [1:0] REQ_LOOKUP   = 2'd0;
  localparam logic [1:0] REQ_REGISTER = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  localparam logic [2:0] ST_NOT_FOUND = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_ADDED     = 3'd2;
  localparam logic [2:0] ST_REFRESHED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [7:0] LEASE_RESET = 8'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] program_id;
    logic [15:0] program_ver;
    logic [15:0] procedure_id;
    logic [31:0] endpoint_ip;
    logic [15:0] endpoint_port;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_ip;
    logic [15:0] found_port;
  } rsp_t;

endpackage

/* design/service_registry_round_robin.sv */
// service registry: ring of service slots rotating past one update stage
// busy while the ring makes one full rotation per item; result strobe on the cycle after busy falls, none for a tick
// a new item is taken only while idle, once the previous ring rotation has finished
// an unknown request type is not taken: busy stays low and it gives no result
// reset empties the table and sets the lease reload to 2
module service_registry_round_robin import srr_pkg::*; #(
  parameter int NUM_SERVICES    = 16,
  parameter int EPS_PER_SERVICE = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int EPS  = EPS_PER_SERVICE;
  localparam int CW   = $clog2(EPS + 1);
  localparam int PW   = (EPS > 1) ? $clog2(EPS) : 1;
  localparam int CNTW = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic            state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic            rsp_valid_q, rsp_valid_d;
  rsp_t            rsp_q, rsp_d;
  req_t            req_q, req_d;
  logic [7:0]      reload_q;

  logic                 c_valid [NUM_SERVICES];
  logic [47:0]          c_key   [NUM_SERVICES];
  logic [CW-1:0]        c_cnt   [NUM_SERVICES];
  logic [PW-1:0]        c_ptr   [NUM_SERVICES];
  logic [EPS-1:0][47:0] c_addr  [NUM_SERVICES];
  logic [EPS-1:0][7:0]  c_lease [NUM_SERVICES];

  logic                 p_valid;
  logic [47:0]          p_key;
  logic [CW-1:0]        p_cnt;
  logic [PW-1:0]        p_ptr;
  logic [EPS-1:0][47:0] p_addr;
  logic [EPS-1:0][7:0]  p_lease;
  logic                 p_hit;
  rsp_t                 p_rsp;

  logic shift;
  logic last;

  assign shift = (state_q == S_RUN);
  assign last  = (cnt_q == CNTW'(NUM_SERVICES - 1));

  srr_proc #(.EPS(EPS), .CW(CW), .PW(PW)) u_proc (
    .req_i    (req_q),
    .reload_i (reload_q),
    .done_i   (done_q),
    .valid_i  (c_valid[0]),
    .key_i    (c_key[0]),
    .cnt_i    (c_cnt[0]),
    .ptr_i    (c_ptr[0]),
    .addr_i   (c_addr[0]),
    .lease_i  (c_lease[0]),
    .valid_o  (p_valid),
    .key_o    (p_key),
    .cnt_o    (p_cnt),
    .ptr_o    (p_ptr),
    .addr_o   (p_addr),
    .lease_o  (p_lease),
    .hit_o    (p_hit),
    .rsp_o    (p_rsp)
  );

  for (genvar i = 0; i < NUM_SERVICES; i++) begin : g_cell
    if (i == NUM_SERVICES - 1) begin : g_tail
      srr_cell #(.EPS(EPS), .CW(CW), .PW(PW)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(p_valid), .key_i(p_key), .cnt_i(p_cnt), .ptr_i(p_ptr),
        .addr_i(p_addr), .lease_i(p_lease),
        .valid_o(c_valid[i]), .key_o(c_key[i]), .cnt_o(c_cnt[i]), .ptr_o(c_ptr[i]),
        .addr_o(c_addr[i]), .lease_o(c_lease[i])
      );
    end else begin : g_mid
      srr_cell #(.EPS(EPS), .CW(CW), .PW(PW)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(c_valid[i+1]), .key_i(c_key[i+1]), .cnt_i(c_cnt[i+1]),
        .ptr_i(c_ptr[i+1]), .addr_i(c_addr[i+1]), .lease_i(c_lease[i+1]),
        .valid_o(c_valid[i]), .key_o(c_key[i]), .cnt_o(c_cnt[i]), .ptr_o(c_ptr[i]),
        .addr_o(c_addr[i]), .lease_o(c_lease[i])
      );
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start && (req_i.req_type == REQ_LOOKUP || req_i.req_type == REQ_REGISTER ||
                      req_i.req_type == REQ_TICK)) begin
          state_d = S_RUN;
          cnt_d   = '0;
          done_d  = 1'b0;
          req_d   = req_i;
          rsp_d   = '0;
          // default answer if no slot claims the item
          rsp_d.status = (req_i.req_type == REQ_REGISTER) ? ST_FULL : ST_NOT_FOUND;
        end
      end
      S_RUN: begin
        if (p_hit) begin
          done_d = 1'b1;
          rsp_d  = p_rsp;
        end
        cnt_d = cnt_q + CNTW'(1);
        if (last) begin
          state_d     = S_IDLE;
          rsp_valid_d = (req_q.req_type != REQ_TICK);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      reload_q    <= LEASE_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) reload_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign busy        = (state_q == S_RUN);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef NO_ASSERTIONS
  a_rsp_after_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy && $past(busy))
    else $error("result strobe outside end of pass");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == ST_NOT_FOUND || rsp_o.status == ST_FOUND ||
                     rsp_o.status == ST_ADDED || rsp_o.status == ST_REFRESHED ||
                     rsp_o.status == ST_FULL))
    else $error("bad result status");

  a_hit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && done_q) |-> !p_hit)
    else $error("second slot claimed one item");

  a_not_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_FOUND) |-> (rsp_o.found_ip == '0 &&
                                                   rsp_o.found_port == '0))
    else $error("address on non-found result");
`endif

endmodule

/* design/srr_cell.sv */
// one service slot of the rotating ring
module srr_cell import srr_pkg::*; #(
  parameter int EPS = 8,
  parameter int CW  = 4,
  parameter int PW  = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  valid_i,
  input  logic [47:0]           key_i,
  input  logic [CW-1:0]         cnt_i,
  input  logic [PW-1:0]         ptr_i,
  input  logic [EPS-1:0][47:0]  addr_i,
  input  logic [EPS-1:0][7:0]   lease_i,
  output logic                  valid_o,
  output logic [47:0]           key_o,
  output logic [CW-1:0]         cnt_o,
  output logic [PW-1:0]         ptr_o,
  output logic [EPS-1:0][47:0]  addr_o,
  output logic [EPS-1:0][7:0]   lease_o
);

  logic                 valid_q;
  logic [47:0]          key_q;
  logic [CW-1:0]        cnt_q;
  logic [PW-1:0]        ptr_q;
  logic [EPS-1:0][47:0] addr_q;
  logic [EPS-1:0][7:0]  lease_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      ptr_q   <= '0;
    end else if (shift_i) begin
      valid_q <= valid_i;
      cnt_q   <= cnt_i;
      ptr_q   <= ptr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= key_i;
      addr_q  <= addr_i;
      lease_q <= lease_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign cnt_o   = cnt_q;
  assign ptr_o   = ptr_q;
  assign addr_o  = addr_q;
  assign lease_o = lease_q;

endmodule

/* design/srr_proc.sv */
// update of the service record passing the head of the ring
module srr_proc import srr_pkg::*; #(
  parameter int EPS = 8,
  parameter int CW  = 4,
  parameter int PW  = 3
) (
  input  req_t                  req_i,
  input  logic [7:0]            reload_i,
  input  logic                  done_i,
  input  logic                  valid_i,
  input  logic [47:0]           key_i,
  input  logic [CW-1:0]         cnt_i,
  input  logic [PW-1:0]         ptr_i,
  input  logic [EPS-1:0][47:0]  addr_i,
  input  logic [EPS-1:0][7:0]   lease_i,
  output logic                  valid_o,
  output logic [47:0]           key_o,
  output logic [CW-1:0]         cnt_o,
  output logic [PW-1:0]         ptr_o,
  output logic [EPS-1:0][47:0]  addr_o,
  output logic [EPS-1:0][7:0]   lease_o,
  output logic                  hit_o,
  output rsp_t                  rsp_o
);

  logic [47:0]   key;
  logic [47:0]   ep;
  logic          key_eq;
  logic [PW-1:0] p;
  logic          refreshed;
  logic [CW-1:0] n;

  assign key = {req_i.program_id, req_i.program_ver, req_i.procedure_id};
  assign ep  = {req_i.endpoint_ip, req_i.endpoint_port};
  assign key_eq = valid_i && (key_i == key);

  always_comb begin
    valid_o = valid_i;
    key_o   = key_i;
    cnt_o   = cnt_i;
    ptr_o   = ptr_i;
    addr_o  = addr_i;
    lease_o = lease_i;
    hit_o   = 1'b0;
    rsp_o   = '0;
    p       = (CW'(ptr_i) >= cnt_i) ? '0 : ptr_i;
    refreshed = 1'b0;
    n       = '0;
    unique case (req_i.req_type)
      REQ_LOOKUP: begin
        if (!done_i && key_eq && cnt_i != '0) begin
          hit_o        = 1'b1;
          rsp_o.status = ST_FOUND;
          for (int j = 0; j < EPS; j++) begin
            if (p == PW'(j)) begin
              rsp_o.found_ip   = addr_i[j][47:16];
              rsp_o.found_port = addr_i[j][15:0];
            end
          end
          ptr_o = ((CW'(p) + CW'(1)) == cnt_i) ? '0 : PW'(p + PW'(1));
        end
      end
      REQ_REGISTER: begin
        if (!done_i && key_eq) begin
          hit_o = 1'b1;
          // first matching live endpoint gets its lease reloaded
          for (int j = 0; j < EPS; j++) begin
            if (!refreshed && CW'(j) < cnt_i && addr_i[j] == ep) begin
              lease_o[j] = reload_i;
              refreshed  = 1'b1;
            end
          end
          if (refreshed) begin
            rsp_o.status = ST_REFRESHED;
          end else if (cnt_i < CW'(EPS)) begin
            for (int j = 0; j < EPS; j++) begin
              if (CW'(j) == cnt_i) begin
                addr_o[j]  = ep;
                lease_o[j] = reload_i;
              end
            end
            cnt_o        = cnt_i + CW'(1);
            rsp_o.status = ST_ADDED;
          end else begin
            rsp_o.status = ST_FULL;
          end
        end else if (!done_i && !valid_i) begin
          // valid slots form a prefix, so no match exists beyond here
          hit_o        = 1'b1;
          valid_o      = 1'b1;
          key_o        = key;
          cnt_o        = CW'(1);
          ptr_o        = '0;
          addr_o[0]    = ep;
          lease_o[0]   = reload_i;
          rsp_o.status = ST_ADDED;
        end
      end
      REQ_TICK: begin
        if (valid_i) begin
          // keep survivors in order, packed from slot zero
          for (int j = 0; j < EPS; j++) begin
            if (CW'(j) < cnt_i && lease_i[j] > 8'd1) begin
              for (int k = 0; k < EPS; k++) begin
                if (CW'(k) == n) begin
                  addr_o[k]  = addr_i[j];
                  lease_o[k] = lease_i[j] - 8'd1;
                end
              end
              n = n + CW'(1);
            end
          end
          cnt_o = n;
          if (CW'(ptr_i) >= n) ptr_o = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* test/service_registry_round_robin_tb.sv */
// self-checking testbench for the service registry with round-robin lookup and lease aging
module service_registry_round_robin_tb;
  import srr_pkg::*;

  localparam int NSVC = 16;
  localparam int NEPS = 8;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = NSVC + 8;
  localparam int CYCLE_LIMIT = 400000;

  class registry_scoreboard;
    logic [7:0]  reload;
    bit          valid[NSVC];
    logic [47:0] key[NSVC];
    logic [3:0]  count[NSVC];
    logic [2:0]  ptr[NSVC];
    logic [47:0] addr[NSVC*NEPS];
    logic [7:0]  lease[NSVC*NEPS];
    int          used;
    rsp_t        expected_q[$];
    int          errors;

    function new();
      reload = LEASE_RESET;
      used = 0;
      errors = 0;
      foreach (valid[i]) begin
        valid[i] = 0; key[i] = '0; count[i] = '0; ptr[i] = '0;
      end
      foreach (addr[i]) begin
        addr[i] = '0; lease[i] = '0;
      end
    endfunction

    function void age_one(int s);
      int b, j, k;
      b = s * NEPS;
      j = 0;
      while (j < count[s]) begin
        if (lease[b+j] <= 8'd1) begin
          for (k = j; k + 1 < count[s]; k++) begin
            addr[b+k] = addr[b+k+1];
            lease[b+k] = lease[b+k+1];
          end
          count[s] = count[s] - 4'd1;
        end else begin
          lease[b+j] = lease[b+j] - 8'd1;
          j++;
        end
      end
      if (ptr[s] >= count[s]) ptr[s] = '0;
    endfunction

    function void note_item(req_t r);
      logic [47:0] k, a;
      rsp_t e;
      int s, b, p;
      bit done;
      k = {r.program_id, r.program_ver, r.procedure_id};
      a = {r.endpoint_ip, r.endpoint_port};
      e = '0;
      case (r.req_type)
        REQ_LOOKUP: begin
          e.status = ST_NOT_FOUND;
          done = 0;
          for (int i = 0; i < used && !done; i++) begin
            if (valid[i] && key[i] == k && count[i] > 0) begin
              p = ptr[i];
              if (p >= count[i]) p = 0;
              b = i * NEPS;
              e.status = ST_FOUND;
              e.found_ip = addr[b+p][47:16];
              e.found_port = addr[b+p][15:0];
              ptr[i] = 3'((p + 1) % count[i]);
              done = 1;
            end
          end
          expected_q.push_back(e);
        end
        REQ_REGISTER: begin
          s = -1;
          for (int i = 0; i < used && s < 0; i++)
            if (valid[i] && key[i] == k) s = i;
          if (s >= 0) begin
            b = s * NEPS;
            e.status = ST_FULL;
            for (int j = 0; j < count[s] && e.status != ST_REFRESHED; j++) begin
              if (addr[b+j] == a) begin
                lease[b+j] = reload;
                e.status = ST_REFRESHED;
              end
            end
            if (e.status != ST_REFRESHED && count[s] < NEPS) begin
              addr[b+count[s]] = a;
              lease[b+count[s]] = reload;
              count[s] = count[s] + 4'd1;
              e.status = ST_ADDED;
            end
          end else if (used < NSVC) begin
            valid[used] = 1;
            key[used] = k;
            count[used] = 4'd1;
            ptr[used] = '0;
            addr[used*NEPS] = a;
            lease[used*NEPS] = reload;
            used++;
            e.status = ST_ADDED;
          end else begin
            e.status = ST_FULL;
          end
          expected_q.push_back(e);
        end
        REQ_TICK: begin
          for (int i = 0; i < used; i++)
            if (valid[i]) age_one(i);
        end
        default: ;
      endcase
    endfunction

    function void check(rsp_t act);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, act.status);
        errors++;
      end
      if (act.found_ip !== e.found_ip) begin
        $display("%0t: found_ip expected %h actual %h", $time, e.found_ip, act.found_ip);
        errors++;
      end
      if (act.found_port !== e.found_port) begin
        $display("%0t: found_port expected %h actual %h", $time, e.found_port,
                 act.found_port);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       rsp_valid_o;
  rsp_t       rsp_o;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  registry_scoreboard sb;
  logic [47:0] key_pool[20];
  logic [47:0] addr_pool[12];
  int          gap_pct;
  int          cycles;

  service_registry_round_robin u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) sb.check(rsp_o);
  end

  function automatic req_t build(logic [1:0] t, logic [47:0] k, logic [47:0] a);
    req_t r;
    r.req_type = t;
    {r.program_id, r.program_ver, r.procedure_id} = k;
    {r.endpoint_ip, r.endpoint_port} = a;
    return r;
  endfunction

  function automatic req_t random_item();
    int roll;
    logic [1:0] t;
    logic [47:0] k, a;
    roll = $urandom_range(99);
    if (roll < 45) t = REQ_REGISTER;
    else if (roll < 85) t = REQ_LOOKUP;
    else if (roll < 97) t = REQ_TICK;
    else t = REQ_UNKNOWN;
    if ($urandom_range(99) < 5) k = 48'({$urandom, $urandom});
    else k = key_pool[$urandom_range(19)];
    if ($urandom_range(99) < 5) a = 48'({$urandom, $urandom});
    else a = addr_pool[$urandom_range(11)];
    return build(t, k, a);
  endfunction

  task automatic send_item(req_t r);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_item(r);
  endtask

  // wait until every result is in and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reload(logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.reload = v;
    @(posedge clk_i);
  endtask

  initial begin
    int gaps[4];
    logic [7:0] reloads[4];
    sb = new();
    cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    gap_pct = 0;
    foreach (key_pool[i]) key_pool[i] = 48'({$urandom, $urandom});
    foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom, $urandom});
    key_pool[0] = '0;
    key_pool[1] = '1;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset lease, extremes, refresh, expiry, full list, unknown type
    send_item(build(REQ_LOOKUP, '0, '0));
    send_item(build(REQ_REGISTER, '0, '0));
    send_item(build(REQ_REGISTER, '1, '1));
    send_item(build(REQ_REGISTER, '1, '1));
    send_item(build(REQ_LOOKUP, '1, '0));
    send_item(build(REQ_LOOKUP, '0, '1));
    send_item(build(REQ_TICK, '0, '0));
    send_item(build(REQ_LOOKUP, '0, '0));
    send_item(build(REQ_TICK, '0, '0));
    send_item(build(REQ_LOOKUP, '1, '0));
    for (int i = 0; i < 9; i++) send_item(build(REQ_REGISTER, key_pool[2], addr_pool[i]));
    send_item(build(REQ_LOOKUP, key_pool[2], '0));
    send_item(build(REQ_LOOKUP, key_pool[2], '0));
    send_item(build(REQ_UNKNOWN, key_pool[2], '1));
    send_item(build(REQ_TICK, '0, '0));
    send_item(build(REQ_REGISTER, '1, addr_pool[3]));
    drain();

    gaps = '{0, 67, 29, 67};
    reloads = '{8'd1, 8'd255, 8'd2, 8'(3 + $urandom_range(3))};
    for (int ph = 0; ph < 4; ph++) begin
      write_reload(reloads[ph]);
      gap_pct = gaps[ph];
      for (int n = 0; n < 310; n++) send_item(random_item());
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
